[rtl/bsp_pkg.sv]
// Package for the billboard sprite projection block.
// Holds the shared widths, defaults, queue item type and arithmetic helpers.
// No dependencies.
`default_nettype none

package bsp_pkg;

    localparam int COORD_W       = 16;
    localparam int DELTA_W       = 17;
    localparam int ANGLE_W       = 16;
    localparam int TEX_W         = 8;
    localparam int FOV_W         = 15;
    localparam int SIZE_W        = 12;
    localparam int ROW_W         = 13;
    localparam int ROOT_W        = 17;
    localparam int SQ_W          = 34;
    localparam int ROOT_STEPS    = 17;
    localparam int CORDIC_STEPS  = 14;
    localparam int CORDIC_W      = 34;
    localparam int QUEUE_DEPTH   = 4;
    localparam int IN_DATA_W     = 88;
    localparam int OUT_DATA_W    = 88;

    localparam logic [FOV_W-1:0]  FOV_RESET = 15'd10923;
    localparam logic [SIZE_W-1:0] SIZE_MAX  = 12'd4095;

    localparam int VIEW_WIDTH_DEF    = 512;
    localparam int VIEW_HEIGHT_DEF   = 512;
    localparam int IMAGE_HEIGHT_DEF  = 512;
    localparam int TEX_COLS_DEF      = 64;

    // One sprite after the front end: deltas, heading, texture and a flag
    // that marks a sprite sitting exactly on the player.
    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic [ANGLE_W-1:0]        pa;
        logic [TEX_W-1:0]          tex;
        logic                      zero;
    } bsp_item_t;

    function automatic logic [ANGLE_W-1:0] atan_val(input logic [3:0] i);
        logic [ANGLE_W-1:0] r;
        case (i)
            4'd0:    r = 16'd8192;
            4'd1:    r = 16'd4836;
            4'd2:    r = 16'd2555;
            4'd3:    r = 16'd1297;
            4'd4:    r = 16'd651;
            4'd5:    r = 16'd326;
            4'd6:    r = 16'd163;
            4'd7:    r = 16'd81;
            4'd8:    r = 16'd41;
            4'd9:    r = 16'd20;
            4'd10:   r = 16'd10;
            4'd11:   r = 16'd5;
            4'd12:   r = 16'd3;
            4'd13:   r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // Arithmetic shift right that rounds toward zero.
    function automatic logic signed [CORDIC_W-1:0] shr_tz(
        input logic signed [CORDIC_W-1:0] v,
        input int                         s
    );
        logic [CORDIC_W-1:0] mag;
        mag = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
        mag = mag >> s;
        return v[CORDIC_W-1] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

`default_nettype wire

[rtl/bsp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Uses no package; the caller guarantees num_i < den_i * 2**QW.
`default_nettype none

module bsp_div #(
    parameter int NW = 20,
    parameter int DW = 17,
    parameter int QW = 12,
    parameter int SW = 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          vld_i,
    input  wire logic [NW-1:0] num_i,
    input  wire logic [DW-1:0] den_i,
    input  wire logic [SW-1:0] side_i,
    output logic               vld_o,
    output logic [QW-1:0]      quo_o,
    output logic [SW-1:0]      side_o
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic          vld_reg  [1:QW];
    logic [QW-1:0] quo_reg  [1:QW];
    logic [SW-1:0] side_reg [1:QW];
    logic [CW-1:0] rem_reg  [1:QW-1];
    logic [DW-1:0] den_reg  [1:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int BIT = QW - 1 - k;
        logic [CW-1:0] rem_c;
        logic [CW-1:0] trial;
        logic [DW-1:0] den_c;
        logic [QW-1:0] quo_c;
        logic [SW-1:0] side_c;
        logic          vld_c;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_c  = CW'(num_i);
            assign den_c  = den_i;
            assign quo_c  = '0;
            assign side_c = side_i;
            assign vld_c  = vld_i;
        end else begin : g_next
            assign rem_c  = rem_reg[k];
            assign den_c  = den_reg[k];
            assign quo_c  = quo_reg[k];
            assign side_c = side_reg[k];
            assign vld_c  = vld_reg[k];
        end

        assign trial = CW'(den_c) << BIT;
        assign ge    = rem_c >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_c;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k+1]  <= quo_c | (ge ? (QW'(1) << BIT) : '0);
                side_reg[k+1] <= side_c;
            end
        end

        // The last stage needs no remainder or divisor.
        if (k < QW - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= ge ? rem_c - trial : rem_c;
                    den_reg[k+1] <= den_c;
                end
            end
        end
    end

    assign vld_o  = vld_reg[QW];
    assign quo_o  = quo_reg[QW];
    assign side_o = side_reg[QW];

endmodule

`default_nettype wire

[rtl/bsp_front.sv]
// Front end: takes input words, forms the position deltas and the
// coincidence flag, and hands one item at a time to the queue. Uses bsp_pkg.
`default_nettype none

module bsp_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bsp_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                           q_full,
    output logic                                push,
    output bsp_pkg::bsp_item_t                  item
);

    logic               fv_reg;
    bsp_pkg::bsp_item_t item_reg;
    logic [15:0]        px, py, sx, sy;
    logic               take;

    assign px = s_tdata[15:0];
    assign py = s_tdata[31:16];
    assign sx = s_tdata[63:48];
    assign sy = s_tdata[79:64];

    assign s_tready = !fv_reg || !q_full;
    assign take     = s_tvalid && s_tready;
    assign push     = fv_reg && !q_full;
    assign item     = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (take) begin
            fv_reg <= 1'b1;
        end else if (push) begin
            fv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.dx   <= $signed({1'b0, sx}) - $signed({1'b0, px});
            item_reg.dy   <= $signed({1'b0, sy}) - $signed({1'b0, py});
            item_reg.pa   <= s_tdata[47:32];
            item_reg.tex  <= s_tdata[87:80];
            item_reg.zero <= (sx == px) && (sy == py);
        end
    end

endmodule

`default_nettype wire

[rtl/bsp_queue.sv]
// Short queue between the front end and the arithmetic back end.
// Uses bsp_pkg for the item type and depth.
`default_nettype none

module bsp_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire bsp_pkg::bsp_item_t wr_item,
    input  wire logic               pop,
    output bsp_pkg::bsp_item_t      rd_item,
    output logic                    full,
    output logic                    empty
);

    localparam int DEPTH = bsp_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsp_pkg::bsp_item_t mem [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;

    assign full    = cnt_reg == CNT_W'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign rd_item = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

[rtl/bsp_back.sv]
// Back end: squares, integer square root and CORDIC bearing in parallel,
// then size, texture step and column divisions. Uses bsp_pkg and bsp_div.
`default_nettype none

module bsp_back #(
    parameter int VIEW_WIDTH    = bsp_pkg::VIEW_WIDTH_DEF,
    parameter int VIEW_HEIGHT   = bsp_pkg::VIEW_HEIGHT_DEF,
    parameter int IMAGE_HEIGHT  = bsp_pkg::IMAGE_HEIGHT_DEF,
    parameter int TEX_COLS      = bsp_pkg::TEX_COLS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [bsp_pkg::FOV_W-1:0]       fov,
    input  wire logic                            in_valid,
    input  wire bsp_pkg::bsp_item_t              in_item,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [bsp_pkg::OUT_DATA_W-1:0]       m_tdata
);

    localparam int RS    = bsp_pkg::ROOT_STEPS;
    localparam int CS    = bsp_pkg::CORDIC_STEPS;
    localparam int CW    = bsp_pkg::CORDIC_W;
    localparam int SQ_W  = bsp_pkg::SQ_W;
    localparam int RT_W  = bsp_pkg::ROOT_W;
    localparam int REM_W = RT_W + 3;
    localparam int SZ_W  = bsp_pkg::SIZE_W;
    localparam int RW_W  = bsp_pkg::ROW_W;
    localparam int AW    = bsp_pkg::ANGLE_W;
    localparam int TW_   = bsp_pkg::TEX_W;
    localparam int FW    = bsp_pkg::FOV_W;
    localparam int WN_W  = $clog2(VIEW_WIDTH * 256 + 1);
    localparam int HN_W  = $clog2(VIEW_HEIGHT * 256 + 1);
    localparam int SN_W  = $clog2(TEX_COLS * 256 + 1);
    localparam int CMP_W = RT_W + SZ_W;
    localparam int VW_W  = $clog2(VIEW_WIDTH + 1) + 1;
    localparam int P1_W  = RW_W + FW + 1;
    localparam int P2_W  = AW + VW_W;
    localparam int SUM_W = ((P1_W > P2_W) ? P1_W : P2_W) + 1;
    localparam int LQ_W  = 17;
    localparam int SQ_QW = 17;

    localparam logic [WN_W-1:0]        W_NUM  = WN_W'(VIEW_WIDTH * 256);
    localparam logic [HN_W-1:0]        H_NUM  = HN_W'(VIEW_HEIGHT * 256);
    localparam logic [SN_W-1:0]        S_NUM  = SN_W'(TEX_COLS * 256);
    localparam logic signed [VW_W-1:0] VW_S   = VW_W'(VIEW_WIDTH);

    typedef struct packed {
        logic [AW-1:0]  offset;
        logic [TW_-1:0] tex;
        logic           wsat;
    } wside_t;

    typedef struct packed {
        logic                   neg;
        logic                   lsat;
        logic [SZ_W-1:0]        w;
        logic [SZ_W-1:0]        h;
        logic signed [RW_W-1:0] top;
        logic                   tc;
        logic [15:0]            tbase;
    } lside_t;

    logic adv;
    logic m_vld_reg;
    logic [bsp_pkg::OUT_DATA_W-1:0] m_data_reg;

    assign adv      = !m_vld_reg || m_tready;
    assign pop      = adv && in_valid;
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

    // Stage 1: squares of the deltas.
    logic                       s1_vld_reg;
    logic [SQ_W-2:0]            s1_sqx_reg, s1_sqy_reg;
    bsp_pkg::bsp_item_t         s1_item_reg;
    logic signed [SQ_W-1:0]     prod_x, prod_y;

    assign prod_x = in_item.dx * in_item.dx;
    assign prod_y = in_item.dy * in_item.dy;

    // Stage 2: sum of squares and CORDIC start vector.
    logic                   s2_vld_reg;
    logic [SQ_W-1:0]        s2_n_reg;
    logic signed [CW-1:0]   s2_x_reg, s2_y_reg;
    logic [AW-1:0]          s2_z_reg;
    logic                   s2_zero_reg;
    logic [AW-1:0]          s2_pa_reg;
    logic [TW_-1:0]         s2_tex_reg;
    logic signed [CW-1:0]   xe, ye;

    assign xe = {{(CW - 31){s1_item_reg.dx[16]}}, s1_item_reg.dx, 14'd0};
    assign ye = {{(CW - 31){s1_item_reg.dy[16]}}, s1_item_reg.dy, 14'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg <= pop;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_sqx_reg  <= prod_x[SQ_W-2:0];
            s1_sqy_reg  <= prod_y[SQ_W-2:0];
            s1_item_reg <= in_item;
            s2_n_reg    <= {1'b0, s1_sqx_reg} + {1'b0, s1_sqy_reg};
            // A vector in the left half plane starts turned by a half turn.
            s2_x_reg    <= s1_item_reg.dx[16] ? -xe : xe;
            s2_y_reg    <= s1_item_reg.dx[16] ? -ye : ye;
            s2_z_reg    <= s1_item_reg.dx[16] ? 16'h8000 : 16'h0000;
            s2_zero_reg <= s1_item_reg.zero;
            s2_pa_reg   <= s1_item_reg.pa;
            s2_tex_reg  <= s1_item_reg.tex;
        end
    end

    // Core stages: one root bit per stage, CORDIC iterations in the first ones.
    logic                 c_vld_reg  [1:RS];
    logic [RT_W-1:0]      c_root_reg [1:RS];
    logic [AW-1:0]        c_z_reg    [1:RS];
    logic                 c_zero_reg [1:RS];
    logic [AW-1:0]        c_pa_reg   [1:RS];
    logic [TW_-1:0]       c_tex_reg  [1:RS];
    logic [SQ_W-1:0]      c_n_reg    [1:RS-1];
    logic [REM_W-1:0]     c_rem_reg  [1:RS-1];
    logic signed [CW-1:0] c_x_reg    [1:CS-1];
    logic signed [CW-1:0] c_y_reg    [1:CS-1];

    for (genvar j = 0; j < RS; j++) begin : g_core
        logic                 vld_c, zero_c;
        logic [SQ_W-1:0]      n_c;
        logic [REM_W-1:0]     rem_c, rem_sh, trial;
        logic [RT_W-1:0]      root_c;
        logic [AW-1:0]        z_c, pa_c;
        logic [TW_-1:0]       tex_c;
        logic                 ge;

        if (j == 0) begin : g_first
            assign vld_c  = s2_vld_reg;
            assign n_c    = s2_n_reg;
            assign rem_c  = '0;
            assign root_c = '0;
            assign z_c    = s2_z_reg;
            assign zero_c = s2_zero_reg;
            assign pa_c   = s2_pa_reg;
            assign tex_c  = s2_tex_reg;
        end else begin : g_next
            assign vld_c  = c_vld_reg[j];
            assign n_c    = c_n_reg[j];
            assign rem_c  = c_rem_reg[j];
            assign root_c = c_root_reg[j];
            assign z_c    = c_z_reg[j];
            assign zero_c = c_zero_reg[j];
            assign pa_c   = c_pa_reg[j];
            assign tex_c  = c_tex_reg[j];
        end

        assign rem_sh = {rem_c[REM_W-3:0], n_c[SQ_W-1-2*j -: 2]};
        assign trial  = {1'b0, root_c, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                c_vld_reg[j+1] <= 1'b0;
            end else if (adv) begin
                c_vld_reg[j+1] <= vld_c;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                c_root_reg[j+1] <= {root_c[RT_W-2:0], ge};
                c_zero_reg[j+1] <= zero_c;
                c_pa_reg[j+1]   <= pa_c;
                c_tex_reg[j+1]  <= tex_c;
            end
        end

        if (j < RS - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (adv) begin
                    c_n_reg[j+1]   <= n_c;
                    c_rem_reg[j+1] <= ge ? rem_sh - trial : rem_sh;
                end
            end
        end

        if (j < CS) begin : g_rot
            logic signed [CW-1:0] x_c, y_c, xs, ys;
            if (j == 0) begin : g_xy0
                assign x_c = s2_x_reg;
                assign y_c = s2_y_reg;
            end else begin : g_xyn
                assign x_c = c_x_reg[j];
                assign y_c = c_y_reg[j];
            end
            assign xs = bsp_pkg::shr_tz(x_c, j);
            assign ys = bsp_pkg::shr_tz(y_c, j);

            always_ff @(posedge aclk) begin
                if (adv) begin
                    c_z_reg[j+1] <= (y_c > 0) ? z_c + bsp_pkg::atan_val(4'(j))
                                              : z_c - bsp_pkg::atan_val(4'(j));
                end
            end

            if (j < CS - 1) begin : g_xyr
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        c_x_reg[j+1] <= (y_c > 0) ? x_c + ys : x_c - ys;
                        c_y_reg[j+1] <= (y_c > 0) ? y_c - xs : y_c + xs;
                    end
                end
            end
        end else begin : g_pass
            always_ff @(posedge aclk) begin
                if (adv) begin
                    c_z_reg[j+1] <= z_c;
                end
            end
        end
    end

    // Stage 3: bearing offset and size saturation checks.
    logic            s3_vld_reg;
    logic [RT_W-1:0] s3_d_reg;
    wside_t          s3_wside_reg;
    logic            s3_hsat_reg;
    logic [RT_W-1:0] root_d;
    logic [AW-1:0]   bearing;

    assign root_d  = c_root_reg[RS];
    assign bearing = c_zero_reg[RS] ? '0 : c_z_reg[RS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (adv) begin
            s3_vld_reg <= c_vld_reg[RS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_d_reg            <= root_d;
            s3_wside_reg.offset <= bearing - c_pa_reg[RS];
            s3_wside_reg.tex    <= c_tex_reg[RS];
            s3_wside_reg.wsat   <= (root_d == '0) ||
                                   (CMP_W'(W_NUM) >= {root_d, {SZ_W{1'b0}}});
            s3_hsat_reg         <= (root_d == '0) ||
                                   (CMP_W'(H_NUM) >= {root_d, {SZ_W{1'b0}}});
        end
    end

    logic            wd_vld, hd_vld;
    logic [SZ_W-1:0] wq, hq;
    logic [$bits(wside_t)-1:0] wd_side;
    wside_t          ws;
    logic            hd_sat;

    bsp_div #(.NW(WN_W), .DW(RT_W), .QW(SZ_W), .SW($bits(wside_t))) u_wdiv (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .vld_i(s3_vld_reg),
        .num_i(W_NUM), .den_i(s3_d_reg), .side_i(s3_wside_reg),
        .vld_o(wd_vld), .quo_o(wq), .side_o(wd_side)
    );

    bsp_div #(.NW(HN_W), .DW(RT_W), .QW(SZ_W), .SW(1)) u_hdiv (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .vld_i(s3_vld_reg),
        .num_i(H_NUM), .den_i(s3_d_reg), .side_i(s3_hsat_reg),
        .vld_o(hd_vld), .quo_o(hq), .side_o(hd_sat)
    );

    assign ws = wside_t'(wd_side);

    // Stage 4: sizes, base column, top row and texture base.
    logic                   s4_vld_reg;
    logic [SZ_W-1:0]        s4_w_reg, s4_h_reg;
    logic                   s4_tc_reg;
    logic signed [RW_W-1:0] s4_base_reg, s4_top_reg;
    logic [15:0]            s4_tbase_reg;
    logic [AW-1:0]          s4_off_reg;
    logic [SZ_W-1:0]        w_v, h_v;

    assign w_v = ws.wsat ? bsp_pkg::SIZE_MAX : wq;
    assign h_v = hd_sat ? bsp_pkg::SIZE_MAX : hq;

    // Stage 5: products; stage 6: numerator; stage 7: magnitude and sign.
    logic                    s5_vld_reg, s6_vld_reg, s7_vld_reg;
    logic signed [P1_W-1:0]  s5_p1_reg;
    logic signed [P2_W-1:0]  s5_p2_reg;
    logic signed [SUM_W-1:0] s6_sum_reg;
    logic [SUM_W-1:0]        s7_abs_reg;
    lside_t                  s5_side_reg, s6_side_reg, s7_side_reg;
    logic signed [FW:0]      fov_s;
    logic [SUM_W-1:0]        sum_abs;
    lside_t                  s7_side_c;

    assign fov_s = $signed({1'b0, fov});

    always_comb begin
        sum_abs        = s6_sum_reg[SUM_W-1] ? SUM_W'(-s6_sum_reg) : SUM_W'(s6_sum_reg);
        s7_side_c      = s6_side_reg;
        s7_side_c.neg  = s6_sum_reg[SUM_W-1];
        // A quotient of 65536 or more always clamps, so skip those.
        s7_side_c.lsat = 32'(sum_abs) >= {1'b0, fov, 16'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end else if (adv) begin
            s4_vld_reg <= wd_vld && hd_vld;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_w_reg     <= w_v;
            s4_h_reg     <= h_v;
            s4_tc_reg    <= ws.wsat || hd_sat;
            s4_base_reg  <= $signed(RW_W'(VIEW_WIDTH / 2)) - $signed({2'b00, w_v[SZ_W-1:1]});
            s4_top_reg   <= $signed(RW_W'(IMAGE_HEIGHT / 2)) - $signed({2'b00, h_v[SZ_W-1:1]});
            s4_tbase_reg <= 16'(32'(ws.tex) * TEX_COLS);
            s4_off_reg   <= ws.offset;

            s5_p1_reg         <= s4_base_reg * fov_s;
            s5_p2_reg         <= $signed(s4_off_reg) * VW_S;
            s5_side_reg.neg   <= 1'b0;
            s5_side_reg.lsat  <= 1'b0;
            s5_side_reg.w     <= s4_w_reg;
            s5_side_reg.h     <= s4_h_reg;
            s5_side_reg.top   <= s4_top_reg;
            s5_side_reg.tc    <= s4_tc_reg;
            s5_side_reg.tbase <= s4_tbase_reg;

            s6_sum_reg  <= SUM_W'(s5_p1_reg) + SUM_W'(s5_p2_reg);
            s6_side_reg <= s5_side_reg;

            s7_abs_reg  <= sum_abs;
            s7_side_reg <= s7_side_c;
        end
    end

    logic                      ld_vld, sd_vld, sd_wzero;
    logic [LQ_W-1:0]           lq;
    logic [SQ_QW-1:0]          sq;
    logic [$bits(lside_t)-1:0] ld_side;
    lside_t                    ls;

    bsp_div #(.NW(SUM_W), .DW(FW), .QW(LQ_W), .SW($bits(lside_t))) u_ldiv (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .vld_i(s7_vld_reg),
        .num_i(s7_abs_reg), .den_i(fov), .side_i(s7_side_reg),
        .vld_o(ld_vld), .quo_o(lq), .side_o(ld_side)
    );

    bsp_div #(.NW(SN_W), .DW(SZ_W), .QW(SQ_QW), .SW(1)) u_sdiv (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .vld_i(s7_vld_reg),
        .num_i(S_NUM), .den_i(s7_side_reg.w), .side_i(s7_side_reg.w == '0),
        .vld_o(sd_vld), .quo_o(sq), .side_o(sd_wzero)
    );

    assign ls = lside_t'(ld_side);

    logic [15:0] left_v, step_v;

    always_comb begin
        if (ls.lsat) begin
            left_v = ls.neg ? 16'h8000 : 16'h7FFF;
        end else if (ls.neg) begin
            left_v = (lq > LQ_W'(32768)) ? 16'h8000 : 16'(-lq);
        end else begin
            left_v = (lq > LQ_W'(32767)) ? 16'h7FFF : lq[15:0];
        end
        if (sd_wzero) begin
            step_v = 16'd0;
        end else begin
            step_v = sq[SQ_QW-1] ? 16'hFFFF : sq[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (adv) begin
            m_vld_reg <= ld_vld && sd_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {2'b00, ls.tc, step_v, ls.tbase, ls.h, ls.w, ls.top, left_v};
        end
    end

endmodule

`default_nettype wire

[rtl/billboard_sprite_projection_top.sv]
// Top level of the billboard sprite projection block.
// Depends on bsp_pkg, bsp_front, bsp_queue and bsp_back.
//
// Channel   Direction  Handshake             Contents
// s_        in         s_tvalid / s_tready   player and sprite position, heading, texture
// m_        out        m_tvalid / m_tready   column, row, sizes, texture base/step, flag
// cfg_      in         cfg_wr_en             field of view
//
// One word is accepted per cycle and one result leaves per cycle while m_tready is held high.
// From the accepting edge to m_tvalid a word passes 2 front and queue stages,
// 2 setup stages, 17 root stages (CORDIC runs alongside), 1 check stage,
// 12 size divider stages, 4 column setup stages, 17 column divider stages and
// the output register.
// Reset is synchronous and active low; the field of view returns to 10923.
// A stalled output holds the whole back pipeline; the queue lets the front
// end keep taking words until it fills.
`default_nettype none

module billboard_sprite_projection_top #(
    parameter int VIEW_WIDTH    = bsp_pkg::VIEW_WIDTH_DEF,
    parameter int VIEW_HEIGHT   = bsp_pkg::VIEW_HEIGHT_DEF,
    parameter int IMAGE_HEIGHT  = bsp_pkg::IMAGE_HEIGHT_DEF,
    parameter int TEX_COLS      = bsp_pkg::TEX_COLS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bsp_pkg::FOV_W-1:0]         cfg_wr_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // player x, player y, player heading, target x, target y, texture index
    input  wire logic [bsp_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // left column, top row, projected width, projected height, texture base,
    // texture step, too_close, two zero bits
    output logic [bsp_pkg::OUT_DATA_W-1:0]         m_tdata
);

    logic [bsp_pkg::FOV_W-1:0] fov_reg;
    logic [bsp_pkg::FOV_W-1:0] fov_eff;
    logic                      push, pop, q_full, q_empty;
    bsp_pkg::bsp_item_t        f_item, q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fov_reg <= bsp_pkg::FOV_RESET;
        end else if (cfg_wr_en) begin
            fov_reg <= cfg_wr_data;
        end
    end

    // A field of view of zero behaves as one.
    assign fov_eff = (fov_reg == '0) ? bsp_pkg::FOV_W'(1) : fov_reg;

    bsp_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .q_full(q_full), .push(push), .item(f_item)
    );

    bsp_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .wr_item(f_item), .pop(pop), .rd_item(q_item),
        .full(q_full), .empty(q_empty)
    );

    bsp_back #(
        .VIEW_WIDTH(VIEW_WIDTH), .VIEW_HEIGHT(VIEW_HEIGHT),
        .IMAGE_HEIGHT(IMAGE_HEIGHT), .TEX_COLS(TEX_COLS)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .fov(fov_eff),
        .in_valid(!q_empty), .in_item(q_item), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule

`default_nettype wire

[tb/sv/bsp_checker.sv]
// Checker for the billboard sprite projection block: watches both streams and the
// configuration port, predicts each result and compares it field by field.
// Depends on bsp_pkg for the field of view width and reset value.
`timescale 1ns / 100ps

module bsp_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [14:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [87:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [87:0] m_tdata,
    output int               errors,
    output int               pending
);

    typedef struct packed {
        logic [15:0] left_column;
        logic [12:0] top_row;
        logic [11:0] proj_width;
        logic [11:0] proj_height;
        logic [15:0] texture_base;
        logic [15:0] texture_step;
        logic        too_close;
    } sprite_proj_t;

    localparam int ATAN_LUT [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
                                     10, 5, 3, 1};

    logic [bsp_pkg::FOV_W-1:0] fov_reg;
    sprite_proj_t              proj_q[$];

    function automatic longint trunc_shift(longint v, int s);
        if (v < 0) return -((-v) >>> s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint root;
        longint bitv;
        root = 0;
        bitv = longint'(1) << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [15:0] sprite_bearing(longint dx, longint dy);
        longint x, y, z, xs, ys;
        x = dx * 16384;
        y = dy * 16384;
        z = 0;
        if (dx == 0 && dy == 0) return 16'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32768;
        end
        for (int i = 0; i < 14; i++) begin
            xs = trunc_shift(x, i);
            ys = trunc_shift(y, i);
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_LUT[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_LUT[i];
            end
        end
        return z[15:0];
    endfunction

    function automatic sprite_proj_t project_sprite(logic [87:0] w, logic [14:0] fov_val);
        sprite_proj_t r;
        longint dx, dy, span_d, wd, ht, fov, offs, base, left, top, step;
        logic [15:0] diff;
        logic sat;
        dx = longint'(w[63:48]) - longint'(w[15:0]);
        dy = longint'(w[79:64]) - longint'(w[31:16]);
        span_d = int_sqrt(dx * dx + dy * dy);
        sat = 1'b0;
        if (span_d == 0) begin
            wd = 4095;
            ht = 4095;
            sat = 1'b1;
        end else begin
            wd = (512 * 256) / span_d;
            ht = (512 * 256) / span_d;
            if (wd > 4095) begin
                wd = 4095;
                sat = 1'b1;
            end
            if (ht > 4095) begin
                ht = 4095;
                sat = 1'b1;
            end
        end
        diff = sprite_bearing(dx, dy) - w[47:32];
        offs = longint'($signed(diff));
        fov = (fov_val == 0) ? 1 : longint'(fov_val);
        base = 256 - wd / 2;
        left = (base * fov + offs * 512) / fov;
        if (left > 32767) left = 32767;
        if (left < -32768) left = -32768;
        top = 256 - ht / 2;
        step = 0;
        if (wd != 0) begin
            step = (64 * 256) / wd;
            if (step > 65535) step = 65535;
        end
        r.left_column   = left[15:0];
        r.top_row       = top[12:0];
        r.proj_width    = wd[11:0];
        r.proj_height   = ht[11:0];
        r.texture_base  = 16'(w[87:80] * 64);
        r.texture_step  = step[15:0];
        r.too_close     = sat;
        return r;
    endfunction

    always @(posedge aclk) begin
        sprite_proj_t got, exp_r;
        if (!aresetn) begin
            fov_reg <= bsp_pkg::FOV_RESET;
        end else begin
            if (cfg_wr_en) fov_reg <= cfg_wr_data;
            if (s_tvalid && s_tready) proj_q.push_back(project_sprite(s_tdata, fov_reg));
            if (m_tvalid && m_tready) begin
                got.left_column   = m_tdata[15:0];
                got.top_row       = m_tdata[28:16];
                got.proj_width    = m_tdata[40:29];
                got.proj_height   = m_tdata[52:41];
                got.texture_base  = m_tdata[68:53];
                got.texture_step  = m_tdata[84:69];
                got.too_close     = m_tdata[85];
                if (proj_q.size() == 0) begin
                    $error("result word with no sprite outstanding");
                    errors++;
                end else begin
                    exp_r = proj_q.pop_front();
                    if (got.left_column !== exp_r.left_column) begin
                        $error("left_column exp %0h got %0h", exp_r.left_column,
                               got.left_column);
                        errors++;
                    end
                    if (got.top_row !== exp_r.top_row) begin
                        $error("top_row exp %0h got %0h", exp_r.top_row, got.top_row);
                        errors++;
                    end
                    if (got.proj_width !== exp_r.proj_width) begin
                        $error("proj_width exp %0d got %0d", exp_r.proj_width,
                               got.proj_width);
                        errors++;
                    end
                    if (got.proj_height !== exp_r.proj_height) begin
                        $error("proj_height exp %0d got %0d", exp_r.proj_height,
                               got.proj_height);
                        errors++;
                    end
                    if (got.texture_base !== exp_r.texture_base) begin
                        $error("texture_base exp %0d got %0d", exp_r.texture_base,
                               got.texture_base);
                        errors++;
                    end
                    if (got.texture_step !== exp_r.texture_step) begin
                        $error("texture_step exp %0d got %0d", exp_r.texture_step,
                               got.texture_step);
                        errors++;
                    end
                    if (got.too_close !== exp_r.too_close) begin
                        $error("too_close exp %0b got %0b", exp_r.too_close,
                               got.too_close);
                        errors++;
                    end
                end
            end
        end
        pending <= proj_q.size();
    end

    initial errors = 0;

endmodule

[tb/sv/billboard_sprite_projection_top_tb.sv]
// Testbench top for the billboard sprite projection block: drives sprites and
// field of view settings, stalls the output, and gives the verdict.
// Depends on bsp_pkg, the block and bsp_checker.
`timescale 1ns / 100ps

module billboard_sprite_projection_top_tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [14:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    bit          send_burst = 1'b0;

    always #2 aclk = ~aclk;

    billboard_sprite_projection_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    bsp_checker chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The receiver runs in stretches; the first long hold-off lets the block fill.
    initial begin
        int cyc;
        cyc = 0;
        @(posedge aresetn);
        while (1) begin
            @(posedge aclk);
            cyc++;
            if (cyc == 600) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else if ((cyc / 300) % 3 == 2) begin
                m_tready <= 1'b1;
            end else if (pick_gap() == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
            end
        end
    end

    task automatic send_sprite(logic [15:0] px, logic [15:0] py, logic [15:0] pa,
                               logic [15:0] sx, logic [15:0] sy, logic [7:0] tex);
        int gap;
        s_tdata  <= {tex, sy, sx, pa, py, px};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        gap = send_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_and_config(logic [14:0] fov);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= fov;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly sprites near the player so sizes, columns and saturation all vary.
    task automatic random_sprite();
        logic [15:0] px, py, sx, sy;
        int span;
        int r;
        r = $urandom_range(0, 9);
        px = 16'($urandom);
        py = 16'($urandom);
        if (r < 8) begin
            span = (r < 2) ? 200 : ((r < 5) ? 3000 : 20000);
            sx = 16'(int'(px) + $urandom_range(0, 2 * span) - span);
            sy = 16'(int'(py) + $urandom_range(0, 2 * span) - span);
            if (r == 0) sx = px;
        end else begin
            sx = 16'($urandom);
            sy = 16'($urandom);
        end
        send_sprite(px, py, 16'($urandom), sx, sy, 8'($urandom));
    endtask

    initial begin
        logic [14:0] fovs [5];
        fovs = '{15'd10923, 15'd1, 15'd32767, 15'd0, 15'd5000};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: coincident sprite, extreme coordinates, each quadrant, angle wrap.
        send_sprite(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00);
        send_sprite(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff);
        send_sprite(16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 8'h01);
        send_sprite(16'hffff, 16'hffff, 16'h8000, 16'h0000, 16'h0000, 8'h80);
        send_sprite(16'hffff, 16'h0000, 16'h4000, 16'h0000, 16'hffff, 8'h7f);
        send_sprite(16'h8000, 16'h8000, 16'h0000, 16'h8001, 16'h8000, 8'h02);
        send_sprite(16'h8000, 16'h8000, 16'hc000, 16'h7f00, 16'h8000, 8'h03);
        send_sprite(16'h8000, 16'h8000, 16'h4000, 16'h8000, 16'h8100, 8'h04);
        send_sprite(16'h8000, 16'h8000, 16'hfff0, 16'h8000, 16'h7f00, 8'h05);
        send_sprite(16'h8000, 16'h8000, 16'h0010, 16'h8200, 16'h8000, 8'h06);
        send_sprite(16'h8000, 16'h8000, 16'h7ff0, 16'h7e00, 16'h8001, 8'h07);
        send_sprite(16'h8000, 16'h8000, 16'h8010, 16'h7e00, 16'h7fff, 8'h08);
        send_sprite(16'h1000, 16'h1000, 16'h2000, 16'h1020, 16'h1020, 8'h09);
        send_sprite(16'h1000, 16'h1000, 16'h0000, 16'h1000, 16'h1040, 8'h0a);
        send_sprite(16'h0000, 16'h8000, 16'h0000, 16'hffff, 16'h8000, 8'h0b);
        send_sprite(16'h5555, 16'haaaa, 16'haaaa, 16'haaaa, 16'h5555, 8'h55);
        send_sprite(16'haaaa, 16'h5555, 16'h5555, 16'h5555, 16'haaaa, 8'haa);

        for (int ph = 0; ph < 5; ph++) begin
            if (ph != 0) drain_and_config(fovs[ph]);
            for (int n = 0; n < 160; n++) begin
                send_burst = (n >= 60 && n < 100);
                random_sprite();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Any stretch without a handshake counts, so a stuck input or output ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= 20000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
